// ----- rtl/assert_macros.svh -----
// Assertion macros used by the repeater controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the standard clk_i / rst_ni pair.
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/tar_pkg.sv -----
// Package for the tone access repeater controller: types, codes and phase helpers.
package tar_pkg;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_KEYUP   = 6'b000010,
    PH_WELCOME = 6'b000100,
    PH_REPEAT  = 6'b001000,
    PH_CLOSING = 6'b010000,
    PH_KEYDOWN = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_SECOND = 2'd1,
    CMD_HALF   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PLAY_NONE    = 2'd0,
    PLAY_WELCOME = 2'd1,
    PLAY_CLOSING = 2'd2,
    PLAY_BEEP    = 2'd3
  } play_e;

  typedef enum logic [1:0] {
    REG_SQUELCH = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_ENABLED = 2'd2,
    REG_CTCSS   = 2'd3
  } cfg_reg_e;

  localparam logic [2:0] PHC_IDLE    = 3'd0;
  localparam logic [2:0] PHC_KEYUP   = 3'd1;
  localparam logic [2:0] PHC_WELCOME = 3'd2;
  localparam logic [2:0] PHC_REPEAT  = 3'd3;
  localparam logic [2:0] PHC_CLOSING = 3'd4;
  localparam logic [2:0] PHC_KEYDOWN = 3'd5;

  localparam int AU_INPUT    = 0;
  localparam int AU_ANNOUNCE = 1;
  localparam int AU_SUBTONE  = 2;

  localparam int LED_RX = 0;
  localparam int LED_TX = 1;

  localparam logic [7:0]  CARRIER_LOSS_LIMIT = 8'd10;
  localparam logic [7:0]  STEP_MAX           = 8'hFF;
  localparam logic [15:0] TIMEOUT_MAX        = 16'hFFFF;
  localparam logic [1:0]  BEEP_HOLDOFF       = 2'd2;
  localparam logic [3:0]  SQUELCH_RESET      = 4'd9;
  localparam logic [15:0] TIMEOUT_RESET      = 16'd180;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] signal_s;
    logic       button_level;
    logic       tone_detected;
    logic       playback_busy;
  } item_t;

  typedef struct packed {
    logic        ptt;
    logic        rx_led;
    logic        tx_led;
    logic        input_audio_on;
    logic        announce_audio_on;
    logic        subtone_on;
    logic [1:0]  play_request;
    logic [2:0]  phase;
    logic        carrier_detect;
    logic [15:0] timeout_count;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  step;
    logic [15:0] tmo;
    logic [1:0]  holdoff;
    logic        last_button;
    logic        carrier_now;
    logic        carrier_prev;
    logic        blink;
    logic [2:0]  audio;
    logic [1:0]  leds;
    logic        ptt;
  } state_t;

  localparam state_t ST_RESET = '{
    phase:        PH_IDLE,
    step:         8'd0,
    tmo:          16'd0,
    holdoff:      2'd0,
    last_button:  1'b1,
    carrier_now:  1'b0,
    carrier_prev: 1'b0,
    blink:        1'b0,
    audio:        3'd0,
    leds:         2'd0,
    ptt:          1'b0
  };

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] c;
    unique case (ph)
      PH_IDLE:    c = PHC_IDLE;
      PH_KEYUP:   c = PHC_KEYUP;
      PH_WELCOME: c = PHC_WELCOME;
      PH_REPEAT:  c = PHC_REPEAT;
      PH_CLOSING: c = PHC_CLOSING;
      PH_KEYDOWN: c = PHC_KEYDOWN;
      default:    c = PHC_IDLE;
    endcase
    return c;
  endfunction

  // Entry actions of a phase change; play requests are raised by the caller.
  function automatic state_t go_phase(state_t s, phase_e ph, logic ctcss);
    state_t r;
    r = s;
    r.step = 8'd0;
    unique case (ph)
      PH_IDLE: begin
        r.audio = 3'd0;
        r.ptt   = 1'b0;
      end
      PH_KEYUP: begin
        r.ptt = 1'b1;
      end
      PH_WELCOME: begin
        r.audio[AU_INPUT]    = 1'b0;
        r.audio[AU_ANNOUNCE] = 1'b1;
        if (ctcss) r.audio[AU_SUBTONE] = 1'b1;
      end
      PH_REPEAT: begin
        r.carrier_prev       = s.carrier_now;
        r.audio[AU_INPUT]    = s.carrier_now;
        r.audio[AU_ANNOUNCE] = 1'b0;
        if (ctcss) r.audio[AU_SUBTONE] = 1'b1;
        r.tmo = 16'd0;
      end
      PH_CLOSING: begin
        r.audio[AU_ANNOUNCE] = 1'b1;
        if (ctcss) r.audio[AU_SUBTONE] = 1'b1;
      end
      default: begin
      end
    endcase
    r.phase = ph;
    return r;
  endfunction

endpackage

// ----- rtl/tar_core.sv -----
// Controller state, configuration registers and the per-transaction update logic.
`include "assert_macros.svh"

module tar_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_go_i,
  input  tar_pkg::item_t   item_i,
  input  tar_pkg::cfg_wr_t cfg_i,
  output tar_pkg::result_t result_o
);
  import tar_pkg::*;

  state_t      st_q, st_d;
  logic [3:0]  squelch_q, squelch_d;
  logic [15:0] tlimit_q, tlimit_d;
  logic        enabled_q, enabled_d;
  logic        ctcss_q, ctcss_d;
  play_e       play;
  logic        carrier_new;

  assign carrier_new = (item_i.signal_s >= squelch_q);

  always_comb begin
    st_d      = st_q;
    squelch_d = squelch_q;
    tlimit_d  = tlimit_q;
    enabled_d = enabled_q;
    ctcss_d   = ctcss_q;
    play      = PLAY_NONE;
    if (item_go_i) begin
      case (cmd_e'(item_i.cmd))
        CMD_POLL: begin
          if (enabled_q) begin
            if (!st_d.last_button && item_i.button_level) begin
              st_d = go_phase(st_d, PH_KEYUP, ctcss_q);
            end
            st_d.last_button = item_i.button_level;
            st_d.carrier_now = carrier_new;
            if (carrier_new != st_d.carrier_prev) begin
              if (st_d.phase == PH_REPEAT) begin
                st_d.audio[AU_INPUT] = carrier_new;
                if (!carrier_new && st_d.holdoff == 2'd0) begin
                  st_d.audio[AU_ANNOUNCE] = 1'b1;
                  play                    = PLAY_BEEP;
                  st_d.tmo                = 16'd0;
                  st_d.holdoff            = BEEP_HOLDOFF;
                end
              end else begin
                st_d.audio[AU_INPUT] = 1'b0;
              end
              st_d.carrier_prev = carrier_new;
            end
          end
        end
        CMD_SECOND: begin
          if (enabled_q) begin
            unique case (st_d.phase)
              PH_IDLE: begin
                if (item_i.tone_detected && st_d.carrier_now) begin
                  if (st_d.step != STEP_MAX) st_d.step = st_d.step + 8'd1;
                end else begin
                  st_d.step = 8'd0;
                end
                if (st_d.step != 8'd0) st_d = go_phase(st_d, PH_KEYUP, ctcss_q);
              end
              PH_KEYUP: begin
                if (st_d.step != STEP_MAX) st_d.step = st_d.step + 8'd1;
                if (st_d.step > 8'd1 && !item_i.tone_detected) begin
                  st_d = go_phase(st_d, PH_WELCOME, ctcss_q);
                  play = PLAY_WELCOME;
                end
              end
              PH_WELCOME: begin
                if (!item_i.playback_busy) st_d = go_phase(st_d, PH_REPEAT, ctcss_q);
              end
              PH_REPEAT: begin
                if (!st_d.carrier_now) begin
                  if (st_d.step != STEP_MAX) st_d.step = st_d.step + 8'd1;
                end else begin
                  st_d.step = 8'd0;
                end
                if (st_d.tmo != TIMEOUT_MAX) st_d.tmo = st_d.tmo + 16'd1;
                if (st_d.step > CARRIER_LOSS_LIMIT || st_d.tmo >= tlimit_q) begin
                  st_d = go_phase(st_d, PH_CLOSING, ctcss_q);
                  play = PLAY_CLOSING;
                end
              end
              PH_CLOSING: begin
                if (!item_i.playback_busy) st_d = go_phase(st_d, PH_KEYDOWN, ctcss_q);
              end
              PH_KEYDOWN: begin
                if (st_d.step != STEP_MAX) st_d.step = st_d.step + 8'd1;
                if (st_d.step > 8'd1) st_d = go_phase(st_d, PH_IDLE, ctcss_q);
              end
              default: begin
              end
            endcase
            if (st_d.holdoff != 2'd0) begin
              st_d.holdoff = st_d.holdoff - 2'd1;
              if (st_d.holdoff == 2'd0) st_d.audio[AU_ANNOUNCE] = 1'b0;
            end
          end
        end
        CMD_HALF: begin
          if (st_d.phase == PH_IDLE) begin
            st_d.leds[LED_RX] = st_d.carrier_now ? st_d.blink : 1'b1;
            st_d.leds[LED_TX] = 1'b0;
          end else begin
            st_d.leds[LED_TX] = (!st_d.carrier_now || st_d.phase == PH_CLOSING) ?
                                st_d.blink : 1'b1;
            st_d.leds[LED_RX] = 1'b0;
          end
          st_d.blink = ~st_d.blink;
        end
        default: begin
        end
      endcase
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_SQUELCH: squelch_d = cfg_i.data[3:0];
        REG_TIMEOUT: tlimit_d  = cfg_i.data;
        REG_ENABLED: begin
          enabled_d = cfg_i.data[0];
          if (!cfg_i.data[0]) st_d = go_phase(st_d, PH_IDLE, ctcss_q);
        end
        REG_CTCSS:   ctcss_d   = cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_RESET;
      squelch_q <= SQUELCH_RESET;
      tlimit_q  <= TIMEOUT_RESET;
      enabled_q <= 1'b1;
      ctcss_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      squelch_q <= squelch_d;
      tlimit_q  <= tlimit_d;
      enabled_q <= enabled_d;
      ctcss_q   <= ctcss_d;
    end
  end

  always_comb begin
    result_o.ptt               = st_d.ptt;
    result_o.rx_led            = st_d.leds[LED_RX];
    result_o.tx_led            = st_d.leds[LED_TX];
    result_o.input_audio_on    = st_d.audio[AU_INPUT];
    result_o.announce_audio_on = st_d.audio[AU_ANNOUNCE];
    result_o.subtone_on        = st_d.audio[AU_SUBTONE];
    result_o.play_request      = play;
    result_o.phase             = phase_code(st_d.phase);
    result_o.carrier_detect    = st_d.carrier_now;
    result_o.timeout_count     = st_d.tmo;
  end

  // transmitter is keyed in every phase but idle
  `ASSERT_STD(ptt_matches_phase, st_q.ptt == (st_q.phase != PH_IDLE), "ptt out of step with phase")
  `ASSERT_STD(idle_audio_off, (st_q.phase == PH_IDLE) |-> (st_q.audio == 3'd0), "audio on in idle")
  `ASSERT_STD(holdoff_range, st_q.holdoff <= BEEP_HOLDOFF, "beep holdoff out of range")

endmodule

// ----- rtl/tone_access_repeater_controller.sv -----
// Top level of the tone access repeater controller: input stage, core and result register.
// A transaction goes from the input stage through the core into the result register.
// Throughput: one per cycle unless stalled; input stage and result register hold one each.
// The single state update between input register and result register sets that rate.
// Reset: asynchronous, active low; idle phase, registers at their documented defaults.
// Configuration writes are ready while the input stage is empty.
module tone_access_repeater_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tar_pkg::item_t    in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tar_pkg::result_t  out_result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import tar_pkg::*;

  logic    s1_valid_q, s1_valid_d;
  item_t   s1_item_q, s1_item_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  result_t core_result;
  cfg_wr_t cfg_wr;
  logic    out_free, s1_go, in_fire;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_go       = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !s1_valid_q;

  always_comb begin
    cfg_wr.valid = cfg_valid_i && cfg_ready_o;
    cfg_wr.index = cfg_index_i;
    cfg_wr.data  = cfg_data_i;
  end

  tar_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_go_i(s1_go),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_wr),
    .result_o (core_result)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_item_d   = s1_item_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (s1_go) s1_valid_d = 1'b0;
    if (in_fire) begin
      s1_valid_d = 1'b1;
      s1_item_d  = in_item_i;
    end
    if (s1_go) begin
      out_valid_d = 1'b1;
      out_d       = core_result;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    out_q     <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the repeater controller: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tar_pkg::*;

  localparam int         CYCLE_LIMIT = 400_000;
  localparam int         SEG_ITEMS   = 125;
  localparam int         NUM_SEGS    = 12;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  item_t       in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  result_t     out_result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  tone_access_repeater_controller i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (out_result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // controller mirror
  logic [3:0]  cfg_squelch;
  logic [15:0] cfg_tmo_limit;
  logic        cfg_en;
  logic        cfg_ctcss;
  logic [2:0]  ph_q;
  logic [7:0]  sec_cnt;
  logic [15:0] tmo_cnt;
  logic [1:0]  beep_wait;
  logic        btn_last;
  logic        car;
  logic        car_last;
  logic        blink;
  logic [2:0]  paths;
  logic [1:0]  leds;
  logic        key;
  play_e       play_req;

  result_t     status_q[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_left = 0;
  logic        row_typed;
  result_t     row_result;
  bit          air_on = 1'b0;
  bit          btn_held = 1'b0;

  function automatic void enter_phase(input logic [2:0] ph);
    sec_cnt = 8'd0;
    case (ph)
      PHC_IDLE: begin
        paths = 3'd0;
        key   = 1'b0;
      end
      PHC_KEYUP: begin
        key = 1'b1;
      end
      PHC_WELCOME: begin
        paths[AU_INPUT]    = 1'b0;
        paths[AU_ANNOUNCE] = 1'b1;
        if (cfg_ctcss) paths[AU_SUBTONE] = 1'b1;
        play_req = PLAY_WELCOME;
      end
      PHC_REPEAT: begin
        car_last           = car;
        paths[AU_INPUT]    = car;
        paths[AU_ANNOUNCE] = 1'b0;
        if (cfg_ctcss) paths[AU_SUBTONE] = 1'b1;
        tmo_cnt = 16'd0;
      end
      PHC_CLOSING: begin
        paths[AU_ANNOUNCE] = 1'b1;
        if (cfg_ctcss) paths[AU_SUBTONE] = 1'b1;
        play_req = PLAY_CLOSING;
      end
      default: begin
      end
    endcase
    ph_q = ph;
  endfunction

  function automatic void count_up();
    if (sec_cnt != STEP_MAX) sec_cnt = sec_cnt + 8'd1;
  endfunction

  function automatic void on_poll(input logic [3:0] sig, input logic btn);
    if (!btn_last && btn) enter_phase(PHC_KEYUP);
    btn_last = btn;
    car = (sig >= cfg_squelch);
    if (car != car_last) begin
      if (ph_q == PHC_REPEAT) begin
        paths[AU_INPUT] = car;
        if (!car && beep_wait == 2'd0) begin
          paths[AU_ANNOUNCE] = 1'b1;
          play_req  = PLAY_BEEP;
          tmo_cnt   = 16'd0;
          beep_wait = BEEP_HOLDOFF;
        end
      end else begin
        paths[AU_INPUT] = 1'b0;
      end
      car_last = car;
    end
  endfunction

  function automatic void on_second(input logic tone, input logic busy);
    case (ph_q)
      PHC_IDLE: begin
        if (tone && car) count_up();
        else sec_cnt = 8'd0;
        if (sec_cnt >= 8'd1) enter_phase(PHC_KEYUP);
      end
      PHC_KEYUP: begin
        count_up();
        if (sec_cnt > 8'd1 && !tone) enter_phase(PHC_WELCOME);
      end
      PHC_WELCOME: begin
        if (!busy) enter_phase(PHC_REPEAT);
      end
      PHC_REPEAT: begin
        if (!car) count_up();
        else sec_cnt = 8'd0;
        if (tmo_cnt != TIMEOUT_MAX) tmo_cnt = tmo_cnt + 16'd1;
        if (sec_cnt > CARRIER_LOSS_LIMIT || tmo_cnt >= cfg_tmo_limit) enter_phase(PHC_CLOSING);
      end
      PHC_CLOSING: begin
        if (!busy) enter_phase(PHC_KEYDOWN);
      end
      PHC_KEYDOWN: begin
        count_up();
        if (sec_cnt > 8'd1) enter_phase(PHC_IDLE);
      end
      default: begin
      end
    endcase
    if (beep_wait != 2'd0) begin
      beep_wait = beep_wait - 2'd1;
      if (beep_wait == 2'd0) paths[AU_ANNOUNCE] = 1'b0;
    end
  endfunction

  function automatic void on_half();
    logic rx;
    logic tx;
    if (ph_q == PHC_IDLE) begin
      rx = car ? blink : 1'b1;
      tx = 1'b0;
    end else begin
      tx = (!car || ph_q == PHC_CLOSING) ? blink : 1'b1;
      rx = 1'b0;
    end
    leds[LED_RX] = rx;
    leds[LED_TX] = tx;
    blink = ~blink;
  endfunction

  function automatic void apply_reg(input cfg_reg_e idx, input logic [15:0] val);
    case (idx)
      REG_SQUELCH: cfg_squelch = val[3:0];
      REG_TIMEOUT: cfg_tmo_limit = val;
      REG_ENABLED: begin
        cfg_en = val[0];
        if (!cfg_en) enter_phase(PHC_IDLE);
      end
      default: cfg_ctcss = val[0];
    endcase
  endfunction

  function automatic result_t predict_status(input item_t it);
    result_t r;
    play_req = PLAY_NONE;
    case (it.cmd)
      CMD_POLL:   if (cfg_en) on_poll(it.signal_s, it.button_level);
      CMD_SECOND: if (cfg_en) on_second(it.tone_detected, it.playback_busy);
      CMD_HALF:   on_half();
      default: begin
      end
    endcase
    r.ptt               = key;
    r.rx_led            = leds[LED_RX];
    r.tx_led            = leds[LED_TX];
    r.input_audio_on    = paths[AU_INPUT];
    r.announce_audio_on = paths[AU_ANNOUNCE];
    r.subtone_on        = paths[AU_SUBTONE];
    r.play_request      = play_req;
    r.phase             = ph_q;
    r.carrier_detect    = car;
    r.timeout_count     = tmo_cnt;
    return r;
  endfunction

  function automatic item_t mk(input logic [1:0] cmd, input logic [3:0] sig, input logic btn,
                               input logic tone, input logic busy);
    item_t it;
    it.cmd           = cmd;
    it.signal_s      = sig;
    it.button_level  = btn;
    it.tone_detected = tone;
    it.playback_busy = busy;
    return it;
  endfunction

  function automatic result_t lit(input logic ptt, input logic rx, input logic [2:0] ph,
                                  input logic cd);
    result_t r;
    r                = '0;
    r.ptt            = ptt;
    r.rx_led         = rx;
    r.play_request   = PLAY_NONE;
    r.phase          = ph;
    r.carrier_detect = cd;
    return r;
  endfunction

  // Traffic biased by the mirrored phase so that sessions open, run and close.
  function automatic item_t next_event();
    item_t it;
    int    r;
    r = $urandom_range(99);
    if (r < 3) it.cmd = CMD_UNKNOWN;
    else if (r < 15) it.cmd = CMD_HALF;
    else if (r < 55) it.cmd = CMD_POLL;
    else it.cmd = CMD_SECOND;
    if ($urandom_range(99) < 5) air_on = !air_on;
    if ($urandom_range(99) < 10) it.signal_s = 4'($urandom_range(15));
    else if (air_on) it.signal_s = 4'($urandom_range(15, cfg_squelch));
    else if (cfg_squelch == 4'd0) it.signal_s = 4'd0;
    else it.signal_s = 4'($urandom_range(cfg_squelch - 4'd1));
    if (btn_held) begin
      if ($urandom_range(99) < 30) btn_held = 1'b0;
    end else if ($urandom_range(99) < 2) begin
      btn_held = 1'b1;
    end
    it.button_level = !btn_held;
    case (ph_q)
      PHC_IDLE:  it.tone_detected = ($urandom_range(99) < 70);
      PHC_KEYUP: it.tone_detected = ($urandom_range(99) < 25);
      default:   it.tone_detected = ($urandom_range(99) < 8);
    endcase
    if (ph_q == PHC_WELCOME || ph_q == PHC_CLOSING) it.playback_busy = ($urandom_range(99) < 50);
    else it.playback_busy = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  task automatic check_status(input result_t got, input result_t want);
    if (got.ptt !== want.ptt) report_mismatch("ptt", 16'(got.ptt), 16'(want.ptt));
    if (got.rx_led !== want.rx_led)
      report_mismatch("rx_led", 16'(got.rx_led), 16'(want.rx_led));
    if (got.tx_led !== want.tx_led)
      report_mismatch("tx_led", 16'(got.tx_led), 16'(want.tx_led));
    if (got.input_audio_on !== want.input_audio_on)
      report_mismatch("input_audio_on", 16'(got.input_audio_on), 16'(want.input_audio_on));
    if (got.announce_audio_on !== want.announce_audio_on)
      report_mismatch("announce_audio_on", 16'(got.announce_audio_on),
                      16'(want.announce_audio_on));
    if (got.subtone_on !== want.subtone_on)
      report_mismatch("subtone_on", 16'(got.subtone_on), 16'(want.subtone_on));
    if (got.play_request !== want.play_request)
      report_mismatch("play_request", 16'(got.play_request), 16'(want.play_request));
    if (got.phase !== want.phase)
      report_mismatch("phase", 16'(got.phase), 16'(want.phase));
    if (got.carrier_detect !== want.carrier_detect)
      report_mismatch("carrier_detect", 16'(got.carrier_detect), 16'(want.carrier_detect));
    if (got.timeout_count !== want.timeout_count)
      report_mismatch("timeout_count", got.timeout_count, want.timeout_count);
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("result with none expected", out_result_o.timeout_count, 16'd0);
        end else begin
          want = status_q.pop_front();
          check_status(out_result_o, want);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = predict_status(in_item_i);
        status_q.push_back(row_typed ? row_result : want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // sink side, with one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic send_item(input item_t it, input logic typed, input result_t res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    row_typed  <= typed;
    row_result <= res;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [3:0] sq, input logic [15:0] lim, input logic en,
                            input logic ct);
    cfg_reg_e    idx;
    logic [15:0] val;
    for (int n = 0; n < 4; n++) begin
      idx = cfg_reg_e'(n);
      case (idx)
        REG_SQUELCH: val = (16'($urandom) & 16'hFFF0) | {12'd0, sq};
        REG_TIMEOUT: val = lim;
        REG_ENABLED: val = (16'($urandom) & 16'hFFFE) | {15'd0, en};
        default:     val = (16'($urandom) & 16'hFFFE) | {15'd0, ct};
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(posedge clk_i); while (!cfg_ready_o);
      apply_reg(idx, val);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    dir_row_t    plan [20];
    logic [3:0]  sq;
    logic [15:0] lim;
    logic        ct;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SQUELCH;
    cfg_data_i  = 16'd0;
    row_typed   = 1'b0;
    row_result  = '0;

    cfg_squelch   = SQUELCH_RESET;
    cfg_tmo_limit = TIMEOUT_RESET;
    cfg_en        = 1'b1;
    cfg_ctcss     = 1'b0;
    ph_q          = PHC_IDLE;
    sec_cnt       = 8'd0;
    tmo_cnt       = 16'd0;
    beep_wait     = 2'd0;
    btn_last      = 1'b1;
    car           = 1'b0;
    car_last      = 1'b0;
    blink         = 1'b0;
    paths         = 3'd0;
    leds          = 2'd0;
    key           = 1'b0;
    play_req      = PLAY_NONE;

    plan = '{
      '{mk(CMD_HALF, 4'd0, 1'b0, 1'b0, 1'b0), 1'b1, lit(1'b0, 1'b1, PHC_IDLE, 1'b0)},
      '{mk(CMD_UNKNOWN, 4'd15, 1'b0, 1'b1, 1'b1), 1'b1, lit(1'b0, 1'b1, PHC_IDLE, 1'b0)},
      '{mk(CMD_POLL, 4'd15, 1'b1, 1'b0, 1'b0), 1'b1, lit(1'b0, 1'b1, PHC_IDLE, 1'b1)},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b1, 1'b0), 1'b1, lit(1'b1, 1'b1, PHC_KEYUP, 1'b1)},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b1, 1'b0), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b1), 1'b0, '0},
      '{mk(CMD_HALF, 4'd15, 1'b1, 1'b1, 1'b1), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_POLL, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_POLL, 4'd15, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_POLL, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b1, 1'b1), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_POLL, 4'd9, 1'b0, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_POLL, 4'd8, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_HALF, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0},
      '{mk(CMD_SECOND, 4'd0, 1'b1, 1'b0, 1'b0), 1'b0, '0}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 38;
    rx_idle_pct = 69;
    foreach (plan[i]) send_item(plan[i].it, plan[i].typed, plan[i].res);

    // disable while repeating, then poll and tick with the controller frozen; the half tick still drives the LEDs
    wait_idle();
    set_config(SQUELCH_RESET, TIMEOUT_RESET, 1'b0, 1'b0);
    send_item(mk(CMD_POLL, 4'd15, 1'b1, 1'b1, 1'b0), 1'b0, '0);
    send_item(mk(CMD_SECOND, 4'd15, 1'b1, 1'b1, 1'b0), 1'b0, '0);
    send_item(mk(CMD_HALF, 4'd15, 1'b1, 1'b1, 1'b0), 1'b0, '0);

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      case (seg / 4)
        0: begin
          tx_idle_pct = 38;
          rx_idle_pct = 69;
        end
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 38;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (seg % 6)
        0: begin sq = 4'd0;  lim = 16'd0;     ct = 1'b1; end
        1: begin sq = 4'd15; lim = 16'hFFFF;  ct = 1'b0; end
        2: begin sq = SQUELCH_RESET; lim = TIMEOUT_RESET; ct = 1'b0; end
        3: begin sq = 4'd5;  lim = 16'd8;     ct = 1'b1; end
        4: begin sq = 4'd12; lim = 16'd1;     ct = 1'b1; end
        default: begin
          sq  = 4'($urandom_range(15));
          lim = 16'($urandom_range(30, 1));
          ct  = 1'($urandom_range(1));
        end
      endcase
      if (seg % 4 == 3) begin
        set_config(sq, lim, 1'b0, ct);
        repeat (10) send_item(next_event(), 1'b0, '0);
        wait_idle();
      end
      set_config(sq, lim, 1'b1, ct);
      if (seg == 8) hold_left = 120;
      repeat (SEG_ITEMS) send_item(next_event(), 1'b0, '0);
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
